// File: rtl/core/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define CHK_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

// File: rtl/core/chct_pkg.sv
// ----------------------------------------------------------------------------
// chct_pkg
// Types and codes shared by the credential table modules.
// ----------------------------------------------------------------------------
package chct_pkg;
    localparam int KEY_W  = 56;
    localparam int PASS_W = 40;
    localparam int SLOT_W = 8;
    localparam logic [SLOT_W-1:0] NIL = 8'd128;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BADPASS = 3'd1;
    localparam logic [2:0] ST_NOKEY   = 3'd2;
    localparam logic [2:0] ST_DUP     = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_HEAD, S_READ, S_CMP, S_INS1, S_INS2, S_DEL1, S_DEL2,
        S_DONE
    } t_state;
endpackage

// File: rtl/core/chct_hash.sv
// ----------------------------------------------------------------------------
// chct_hash
// Key and password normalization and bucket index computation.
// ----------------------------------------------------------------------------
module chct_hash
    import chct_pkg::*;
#(
    parameter int BUCKETS    = 10,
    parameter int KEY_CHARS  = 7,
    parameter int PASS_CHARS = 5,
    parameter int BW         = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
    input  logic [KEY_W-1:0]  i_key,
    input  logic [2:0]        i_key_length,
    input  logic [PASS_W-1:0] i_password,
    output logic [KEY_W-1:0]  o_key,
    output logic [PASS_W-1:0] o_pass,
    output logic [BW-1:0]     o_bucket
);
    // reciprocal of BUCKETS, exact for a dividend below 256
    localparam int RECIP = (65536 + BUCKETS - 1) / BUCKETS;

    logic [3:0]  len;
    logic [7:0]  last;
    logic [8:0]  sum;
    logic [7:0]  half;
    logic [24:0] prod;
    logic [7:0]  quo;
    logic [7:0]  rem;

    always_comb begin
        len = (32'(i_key_length) > KEY_CHARS) ? 4'(KEY_CHARS) : {1'b0, i_key_length};
        for (int i = 0; i < 7; i++) begin
            o_key[8*i +: 8] = (i < int'(len)) ? i_key[8*i +: 8] : 8'd0;
        end
        for (int i = 0; i < 5; i++) begin
            o_pass[8*i +: 8] = (i < PASS_CHARS) ? i_password[8*i +: 8] : 8'd0;
        end
        last = 8'd0;
        for (int i = 0; i < 7; i++) begin
            if (int'(len) == i + 1) last = o_key[8*i +: 8];
        end
        sum  = {1'b0, o_key[7:0]} + {1'b0, last};
        half = sum[8:1];
        prod = 25'(half) * 25'(RECIP);
        quo  = prod[23:16];
        rem  = 8'(32'(half) - 32'(quo) * BUCKETS);
        if (len == 4'd0) rem = 8'd0;
        o_bucket = BW'(rem);
    end
endmodule

// File: rtl/core/chained_hash_credential_table_unit.sv
// Each request passes S_HEAD, then S_READ and S_CMP per chain entry compared,
// and S_DONE; a miss ends in a final S_READ, a delete hit adds S_DEL1 and S_DEL2,
// an insert miss adds S_INS1 and S_INS2, and a refused insert or the unused mode
// goes from S_HEAD to S_DONE. One transfer in flight; the next input is accepted
// only after the result transfer. Reset: synchronous active low; a clearing pass
// rebuilds the free chain in the link memory, during which no item is accepted.
// ----------------------------------------------------------------------------
// chained_hash_credential_table_unit
// Chained hash table of credentials with a free-slot stack in link memory.
// ----------------------------------------------------------------------------
module chained_hash_credential_table_unit
    import chct_pkg::*;
#(
    parameter int POOL_ENTRIES = 128,
    parameter int BUCKETS      = 10,
    parameter int KEY_CHARS    = 7,
    parameter int PASS_CHARS   = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [2:0]        i_key_length,
    input  logic [PASS_W-1:0] i_password,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_status,
    output logic [SLOT_W-1:0] o_found_slot,
    output logic [SLOT_W-1:0] o_predecessor_slot,
    output logic [SLOT_W-1:0] o_entry_count
);
    localparam int AW = $clog2(POOL_ENTRIES);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SW = (POOL_ENTRIES > 127) ? 9 : 8;

    logic [KEY_W-1:0]  mem_key  [POOL_ENTRIES];
    logic [PASS_W-1:0] mem_pass [POOL_ENTRIES];
    logic [SLOT_W-1:0] mem_link [POOL_ENTRIES];
    logic [SLOT_W-1:0] r_heads  [BUCKETS];

    t_state r_state, n_state;
    logic [1:0]        r_mode;
    logic [KEY_W-1:0]  r_key;
    logic [PASS_W-1:0] r_pass;
    logic [BW-1:0]     r_bkt;
    logic [SLOT_W-1:0] r_cur, r_pred, r_free, r_cnt, r_nw;
    logic [SW-1:0]     r_steps;
    logic [AW:0]       r_init;
    logic              r_ovalid;
    logic [2:0]        r_status;
    logic [SLOT_W-1:0] r_fslot, r_pslot;

    logic [KEY_W-1:0]  h_key, rd_key;
    logic [PASS_W-1:0] h_pass, rd_pass;
    logic [BW-1:0]     h_bkt;
    logic [SLOT_W-1:0] rd_link;

    logic              we;
    logic [AW-1:0]     wa, ra;
    logic [SLOT_W-1:0] wd;
    logic              kwe;
    logic [SLOT_W-1:0] head_wd;
    logic              head_we;

    chct_hash #(.BUCKETS(BUCKETS), .KEY_CHARS(KEY_CHARS), .PASS_CHARS(PASS_CHARS)) u_hash (
        .i_key(i_key), .i_key_length(i_key_length), .i_password(i_password),
        .o_key(h_key), .o_pass(h_pass), .o_bucket(h_bkt)
    );

    function automatic logic valid_slot(input logic [SLOT_W-1:0] s);
        return 32'(s) < POOL_ENTRIES;
    endfunction

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_status = r_status;
    assign o_found_slot = r_fslot;
    assign o_predecessor_slot = r_pslot;
    assign o_entry_count = r_cnt;

    always_comb begin
        n_state = r_state;
        we = 1'b0; wa = '0; wd = '0; ra = r_cur[AW-1:0];
        kwe = 1'b0; head_we = 1'b0; head_wd = NIL;
        unique case (r_state)
            S_INIT: begin
                we = 1'b1; wa = r_init[AW-1:0];
                wd = (32'(r_init) + 1 < POOL_ENTRIES) ? SLOT_W'(r_init + 1'b1) : NIL;
                if (32'(r_init) == POOL_ENTRIES - 1) n_state = S_IDLE;
            end
            S_IDLE: if (i_valid && o_ready) n_state = S_HEAD;
            S_HEAD: begin
                if (r_mode == MODE_INSERT &&
                    (32'(r_cnt) >= POOL_ENTRIES || !valid_slot(r_free)))
                    n_state = S_DONE;
                else if (r_mode == MODE_UNUSED) n_state = S_DONE;
                else n_state = S_READ;
            end
            S_READ: begin
                if (!valid_slot(r_cur) || 32'(r_steps) >= POOL_ENTRIES)
                    n_state = (r_mode == MODE_INSERT) ? S_INS1 : S_DONE;
                else n_state = S_CMP;
            end
            S_CMP: begin
                if (rd_key == r_key)
                    n_state = (r_mode == MODE_DELETE) ? S_DEL1 : S_DONE;
                else n_state = S_READ;
                ra = r_cur[AW-1:0];
            end
            S_INS1: begin
                ra = r_free[AW-1:0];
                kwe = 1'b1;
                if (r_pred != NIL) begin
                    we = 1'b1; wa = r_pred[AW-1:0]; wd = r_free;
                end
                n_state = S_INS2;
            end
            S_INS2: begin
                we = 1'b1; wa = r_nw[AW-1:0]; wd = NIL;
                if (r_pred == NIL) begin
                    head_we = 1'b1; head_wd = r_nw;
                end
                n_state = S_DONE;
            end
            S_DEL1: begin
                if (r_pred != NIL) begin
                    we = 1'b1; wa = r_pred[AW-1:0]; wd = rd_link;
                end else begin
                    head_we = 1'b1; head_wd = rd_link;
                end
                n_state = S_DEL2;
            end
            S_DEL2: begin
                we = 1'b1; wa = r_cur[AW-1:0]; wd = r_free;
                n_state = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem_link[wa] <= wd;
        if (kwe) begin
            mem_key[r_free[AW-1:0]]  <= r_key;
            mem_pass[r_free[AW-1:0]] <= r_pass;
        end
        rd_link <= mem_link[ra];
        rd_key  <= mem_key[ra];
        rd_pass <= mem_pass[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_init <= '0;
            r_free <= '0;
            r_cnt <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < BUCKETS; i++) r_heads[i] <= NIL;
        end else begin
            r_state <= n_state;
            if (head_we) r_heads[r_bkt] <= head_wd;
            if (o_valid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_INIT: r_init <= r_init + 1'b1;
                S_IDLE: if (i_valid && o_ready) begin
                    r_mode <= i_mode; r_key <= h_key; r_pass <= h_pass; r_bkt <= h_bkt;
                end
                S_HEAD: begin
                    r_cur <= r_heads[r_bkt]; r_pred <= NIL; r_steps <= '0;
                    r_status <= (r_mode == MODE_INSERT) ? ST_FULL : ST_NOKEY;
                    r_fslot <= NIL; r_pslot <= NIL;
                end
                S_READ: ;
                S_CMP: begin
                    if (rd_key == r_key) begin
                        r_fslot <= r_cur; r_pslot <= r_pred;
                        unique case (r_mode)
                            MODE_LOOKUP: r_status <= (rd_pass == r_pass) ? ST_OK : ST_BADPASS;
                            MODE_INSERT: r_status <= ST_DUP;
                            default:     r_status <= ST_OK;
                        endcase
                    end else begin
                        r_pred <= r_cur; r_cur <= rd_link; r_steps <= r_steps + 1'b1;
                        r_pslot <= r_cur;
                    end
                end
                S_INS1: r_nw <= r_free;
                S_INS2: begin
                    r_free <= rd_link; r_cnt <= r_cnt + 1'b1;
                    r_status <= ST_OK; r_fslot <= r_nw; r_pslot <= r_pred;
                end
                S_DEL1: ;
                S_DEL2: begin
                    r_free <= r_cur;
                    if (r_cnt != '0) r_cnt <= r_cnt - 1'b1;
                end
                S_DONE: r_ovalid <= 1'b1;
                default: ;
            endcase
        end
    end
endmodule

// File: rtl/core/chct_checker.sv
// ----------------------------------------------------------------------------
// chct_checker
// Port-level checks for the credential table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module chct_checker
    import chct_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [2:0]        o_status,
    input logic [SLOT_W-1:0] o_found_slot,
    input logic [SLOT_W-1:0] o_entry_count
);
    `CHK_IMPL(a_status_range, i_clk, i_rst_n, o_valid, o_status <= ST_FULL)
    `CHK_IMPL(a_one_busy, i_clk, i_rst_n, o_valid, !o_ready)
    `CHK_NEXT(a_no_overlap, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `CHK_IMPL(a_full_nil, i_clk, i_rst_n, o_valid && o_status == ST_FULL, o_found_slot == NIL)
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_entry_count))
endmodule

bind chained_hash_credential_table_unit chct_checker u_chct_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_found_slot(o_found_slot), .o_entry_count(o_entry_count)
);

// File: dv/chained_hash_credential_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_credential_table_unit_tb
// Drives lookup, insert, delete and unused-mode requests into the credential table and
// checks every response against a behavioral table model kept in the bench.
// ----------------------------------------------------------------------------
module chained_hash_credential_table_unit_tb;
    import chct_pkg::*;

    localparam int POOL = 128;
    localparam int NBUCKETS = 10;

    typedef struct {
        logic [2:0]        status;
        logic [SLOT_W-1:0] found;
        logic [SLOT_W-1:0] pred;
        logic [SLOT_W-1:0] count;
    } t_response;

    typedef struct {
        logic [KEY_W-1:0]  key;
        logic [2:0]        len;
        logic [PASS_W-1:0] pw;
    } t_cred;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_mode;
    logic [KEY_W-1:0]  i_key;
    logic [2:0]        i_key_length;
    logic [PASS_W-1:0] i_password;
    logic              o_valid;
    logic              i_ready;
    logic [2:0]        o_status;
    logic [SLOT_W-1:0] o_found_slot;
    logic [SLOT_W-1:0] o_predecessor_slot;
    logic [SLOT_W-1:0] o_entry_count;

    chained_hash_credential_table_unit DUT (.*);

    int                tbl_heads [NBUCKETS];
    logic [KEY_W-1:0]  tbl_keys  [POOL];
    logic [PASS_W-1:0] tbl_pass  [POOL];
    int                tbl_links [POOL];
    int                free_head;
    int                live_count;

    t_response pending_results[$];
    t_cred     known_creds[$];
    int        errors;
    bit        quiet;
    int        hold_off;
    int        stall_left;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #30ms;
        $display("Some tests failed");
        $finish;
    end

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic t_response credential_table_apply(logic [1:0] mode,
            logic [KEY_W-1:0] key_in, logic [2:0] len, logic [PASS_W-1:0] pw);
        t_response r;
        logic [63:0] m;
        logic [KEY_W-1:0] key;
        int b, cur, steps, loc, pred, nw;
        m = (64'h1 << (8 * len)) - 64'h1;
        key = key_in & m[KEY_W-1:0];
        b = (len == 0) ? 0 : ((int'(key[7:0]) + int'((key >> (8 * (len - 1))) & 56'hff)) / 2)
            % NBUCKETS;
        loc = NIL;
        pred = NIL;
        if (mode != MODE_UNUSED) begin
            cur = tbl_heads[b];
            steps = 0;
            while (cur < POOL && steps < POOL) begin
                if (tbl_keys[cur] == key) begin
                    loc = cur;
                    break;
                end
                pred = cur;
                cur = tbl_links[cur];
                steps++;
            end
        end
        r.status = ST_NOKEY;
        r.found = NIL;
        r.pred = NIL;
        case (mode)
            MODE_LOOKUP: begin
                r.found = SLOT_W'(loc);
                r.pred = SLOT_W'(pred);
                if (loc != NIL) r.status = (tbl_pass[loc] == pw) ? ST_OK : ST_BADPASS;
            end
            MODE_INSERT: begin
                if (live_count >= POOL || free_head >= POOL) begin
                    r.status = ST_FULL;
                end else if (loc != NIL) begin
                    r.status = ST_DUP;
                    r.found = SLOT_W'(loc);
                    r.pred = SLOT_W'(pred);
                end else begin
                    nw = free_head;
                    free_head = tbl_links[nw];
                    tbl_keys[nw] = key;
                    tbl_pass[nw] = pw;
                    if (pred == NIL) begin
                        tbl_heads[b] = nw;
                        tbl_links[nw] = NIL;
                    end else begin
                        tbl_links[nw] = tbl_links[pred];
                        tbl_links[pred] = nw;
                    end
                    live_count++;
                    r.status = ST_OK;
                    r.found = SLOT_W'(nw);
                    r.pred = SLOT_W'(pred);
                end
            end
            MODE_DELETE: begin
                r.found = SLOT_W'(loc);
                r.pred = SLOT_W'(pred);
                if (loc != NIL) begin
                    if (pred != NIL) tbl_links[pred] = tbl_links[loc];
                    else tbl_heads[b] = tbl_links[loc];
                    tbl_links[loc] = free_head;
                    free_head = loc;
                    if (live_count > 0) live_count--;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        r.count = SLOT_W'(live_count);
        return r;
    endfunction

    task automatic send_request(logic [1:0] mode, logic [KEY_W-1:0] key, logic [2:0] len,
            logic [PASS_W-1:0] pw);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat ($urandom_range(0, 9)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_mode = mode;
        i_key = key;
        i_key_length = len;
        i_password = pw;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(credential_table_apply(mode, key, len, pw));
    endtask

    always @(posedge i_clk) begin
        t_response want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected transfer", o_status, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) report("status", o_status, want.status);
                if (o_found_slot !== want.found) report("found_slot", o_found_slot, want.found);
                if (o_predecessor_slot !== want.pred)
                    report("predecessor_slot", o_predecessor_slot, want.pred);
                if (o_entry_count !== want.count)
                    report("entry_count", o_entry_count, want.count);
            end
        end
    end

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_ready = 1'b0;
                hold_off--;
            end else if (stall_left > 0) begin
                i_ready = 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                i_ready = 1'b0;
                stall_left = $urandom_range(0, 9);
            end else begin
                i_ready = 1'b1;
            end
        end
    end

    function automatic logic [KEY_W-1:0] rand_key();
        return KEY_W'({$urandom, $urandom});
    endfunction

    function automatic logic [PASS_W-1:0] rand_pw();
        return PASS_W'({$urandom, $urandom});
    endfunction

    task automatic test_directed();
        logic [PASS_W-1:0] ones;
        ones = '1;
        send_request(MODE_LOOKUP, rand_key(), 3'd0, '0);
        send_request(MODE_INSERT, rand_key(), 3'd0, ones);
        send_request(MODE_INSERT, '1, 3'd0, '0);
        send_request(MODE_LOOKUP, '1, 3'd0, ones);
        send_request(MODE_LOOKUP, '0, 3'd0, '0);
        send_request(MODE_INSERT, '1, 3'd7, ones);
        send_request(MODE_LOOKUP, '1, 3'd7, ones);
        send_request(MODE_LOOKUP, '1, 3'd7, 40'h1);
        // two keys sharing one bucket and one key in another bucket
        send_request(MODE_INSERT, 56'h61, 3'd1, 40'h11);
        send_request(MODE_INSERT, 56'hff_ff61, 3'd2, 40'h22);
        send_request(MODE_INSERT, 56'h6161, 3'd2, 40'h33);
        send_request(MODE_INSERT, 56'h6161, 3'd2, 40'h44);
        send_request(MODE_LOOKUP, 56'h6161, 3'd2, 40'h33);
        send_request(MODE_DELETE, 56'h61, 3'd1, '0);
        send_request(MODE_DELETE, 56'h6161, 3'd2, '0);
        send_request(MODE_DELETE, 56'h5a_6161, 3'd2, '0);
        send_request(MODE_DELETE, 56'h6161, 3'd2, '0);
        send_request(MODE_UNUSED, 56'h61, 3'd1, 40'h11);
        send_request(MODE_UNUSED, '1, 3'd7, ones);
        send_request(MODE_INSERT, 56'h61, 3'd1, 40'h55);
        send_request(MODE_LOOKUP, 56'h61, 3'd1, 40'h55);
    endtask

    task automatic test_table_full();
        t_cred c;
        t_cred added[$];
        int tries;
        tries = 0;
        while (live_count < POOL && tries < 400) begin
            c.key = rand_key();
            c.len = 3'($urandom_range(1, 7));
            c.pw = rand_pw();
            added.push_back(c);
            send_request(MODE_INSERT, c.key, c.len, c.pw);
            tries++;
        end
        send_request(MODE_INSERT, rand_key(), 3'd5, rand_pw());
        send_request(MODE_INSERT, '0, 3'd0, '0);
        send_request(MODE_LOOKUP, added[0].key, added[0].len, added[0].pw);
        foreach (added[i]) send_request(MODE_DELETE, added[i].key, added[i].len, '0);
    endtask

    task automatic test_backpressure();
        hold_off = 400;
        repeat (6) send_request(MODE_INSERT, rand_key(), 3'($urandom_range(0, 7)), rand_pw());
    endtask

    task automatic test_random(int n, bit last);
        t_cred c;
        int pick, sel;
        logic [1:0] mode;
        logic [63:0] m;
        for (int i = 0; i < n; i++) begin
            if (last && i == n - 200) quiet = 1'b1;
            if (known_creds.size() < 60 || $urandom_range(0, 9) < 2) begin
                c.key = rand_key();
                c.len = 3'($urandom_range(0, 7));
                c.pw = rand_pw();
                if (known_creds.size() < 60) known_creds.push_back(c);
            end else begin
                pick = $urandom_range(0, known_creds.size() - 1);
                c = known_creds[pick];
                m = (64'h1 << (8 * c.len)) - 64'h1;
                if ($urandom_range(0, 1)) c.key = c.key | (rand_key() & ~m[KEY_W-1:0]);
                if ($urandom_range(0, 2) == 0) c.pw = rand_pw();
            end
            sel = $urandom_range(0, 99);
            mode = (sel < 35) ? MODE_LOOKUP : (sel < 72) ? MODE_INSERT :
                   (sel < 96) ? MODE_DELETE : MODE_UNUSED;
            send_request(mode, c.key, c.len, c.pw);
        end
    endtask

    initial begin
        errors = 0;
        quiet = 1'b0;
        hold_off = 0;
        stall_left = 0;
        i_valid = 1'b0;
        i_mode = MODE_LOOKUP;
        i_key = '0;
        i_key_length = '0;
        i_password = '0;
        foreach (tbl_heads[i]) tbl_heads[i] = NIL;
        foreach (tbl_links[i]) begin
            tbl_links[i] = (i + 1 < POOL) ? i + 1 : NIL;
            tbl_keys[i] = '0;
            tbl_pass[i] = '0;
        end
        free_head = 0;
        live_count = 0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_table_full();
        test_random(600, 1'b0);
        test_backpressure();
        test_random(600, 1'b1);

        @(negedge i_clk);
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

// File: chained_hash_credential_table_unit.f
+incdir+rtl/core
rtl/core/chct_pkg.sv
rtl/core/chct_hash.sv
rtl/core/chained_hash_credential_table_unit.sv
rtl/core/chct_checker.sv
dv/chained_hash_credential_table_unit_tb.sv
